>>> design/cellular_automaton_row_step_assert.svh
// Assertion macros for the automaton row step checker.
// Included by the checker; needs aclk and aresetn in scope.
`ifndef CELLULAR_AUTOMATON_ROW_STEP_ASSERT_SVH
`define CELLULAR_AUTOMATON_ROW_STEP_ASSERT_SVH

// clocked check, off while reset is held
`define CA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also runs through reset
`define CA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> design/carow_pkg.sv
// Shared types and constants for the automaton row step block.
// No dependencies.
package carow_pkg;

    localparam int CELLS_W = 64;
    localparam int WIDTH_W = 7;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd30;

    // 3x3 neighborhood of one cell, bit 1 is the center column
    typedef struct packed {
        logic [2:0] above;
        logic [2:0] mid;
        logic [2:0] below;
    } nbhd_t;

    // result words produced by one accepted input word
    typedef struct packed {
        logic push_a;   // next gen of the held row
        logic push_b;   // next gen of the last row, ends frame
    } push_t;

endpackage

>>> design/carow_lane.sv
// One cell of the update rule.
// Depends on carow_pkg.
module carow_lane
    import carow_pkg::*;
(
    input  nbhd_t nb,
    input  logic  active,
    output logic  cell_next
);

    logic c;
    logic orth;
    logic all8;

    assign c    = nb.mid[1];
    assign orth = nb.above[1] | nb.below[1] | nb.mid[0] | nb.mid[2];
    assign all8 = orth | nb.above[0] | nb.above[2] | nb.below[0] | nb.below[2];

    assign cell_next = active & ((~c & ~orth) | (c & ~all8));

endmodule

>>> design/carow_queue.sv
// Output queue: merges the lane rows into result words, three entries.
// Depends on carow_pkg.
module carow_queue
    import carow_pkg::*;
#(
    parameter int W = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  push_t        push,
    input  logic [W-1:0] row_a,
    input  logic [W-1:0] row_b,
    output logic         space_ok,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [W-1:0] m_row,
    output logic         m_end
);

    localparam int DEPTH = 3;

    logic [W-1:0] data_reg [DEPTH];
    logic         end_reg  [DEPTH];
    logic [1:0]   wr_ptr_reg, wr_ptr_next;
    logic [1:0]   rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    logic         pop;
    logic [1:0]   npush;
    logic [W-1:0] first_row;
    logic         first_end;

    function automatic logic [1:0] inc(input logic [1:0] p);
        return (p == 2'(DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    assign pop       = m_valid & m_ready;
    assign npush     = {1'b0, push.push_a} + {1'b0, push.push_b};
    assign first_row = push.push_a ? row_a : row_b;
    assign first_end = ~push.push_a;

    assign m_valid  = (count_reg != 2'd0);
    assign m_row    = data_reg[rd_ptr_reg];
    assign m_end    = end_reg[rd_ptr_reg];
    assign space_ok = (count_reg <= 2'd1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        if (npush == 2'd1) begin
            wr_ptr_next = inc(wr_ptr_reg);
        end else if (npush == 2'd2) begin
            wr_ptr_next = inc(inc(wr_ptr_reg));
        end
        rd_ptr_next = pop ? inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + npush - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (npush != 2'd0) begin
            data_reg[wr_ptr_reg] <= first_row;
            end_reg[wr_ptr_reg]  <= first_end;
        end
        if (npush == 2'd2) begin
            data_reg[inc(wr_ptr_reg)] <= row_b;
            end_reg[inc(wr_ptr_reg)]  <= 1'b1;
        end
    end

endmodule

>>> design/cellular_automaton_row_step.sv
// Row step of a binary 2-D automaton, one row word per cycle.
// A row's result is formed when the row below it is taken, then registered into the queue.
// Throughput: one row per cycle; a last row that follows a held row emits two
// words, so input is refused while the three-entry queue holds two or more.
// Reset (aresetn, sync, active low): empty frame, queue empty, row_width 30.
// Depends on carow_pkg, carow_lane, carow_queue.
module cellular_automaton_row_step
    import carow_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [WIDTH_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CELLS_W-1:0] s_row_cells,
    input  logic               s_last_row,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CELLS_W-1:0] m_next_cells,
    output logic               m_frame_end
);

    logic [WIDTH_W-1:0]   row_width_reg;
    logic [MAX_WIDTH-1:0] row_above_reg, row_above_next;
    logic [MAX_WIDTH-1:0] row_pending_reg, row_pending_next;
    logic                 pending_valid_reg, pending_valid_next;

    logic                 accept;
    logic [MAX_WIDTH-1:0] mask;
    logic [MAX_WIDTH-1:0] row_in;
    logic [MAX_WIDTH-1:0] row_up;
    logic [MAX_WIDTH+1:0] pad_above, pad_pending, pad_in, pad_up;
    logic [MAX_WIDTH-1:0] next_a, next_b;
    logic [MAX_WIDTH-1:0] q_row;
    push_t                push;

    assign accept = s_valid & s_ready;
    assign row_in = s_row_cells[MAX_WIDTH-1:0] & mask;
    assign row_up = pending_valid_reg ? row_pending_reg : '0;

    assign pad_above   = {1'b0, row_above_reg, 1'b0};
    assign pad_pending = {1'b0, row_pending_reg, 1'b0};
    assign pad_in      = {1'b0, row_in, 1'b0};
    assign pad_up      = {1'b0, row_up, 1'b0};

    genvar i;
    generate
        for (i = 0; i < MAX_WIDTH; i++) begin : g_lane
            nbhd_t nb_a;
            nbhd_t nb_b;

            // lane index below MAX_WIDTH, so this also saturates the width
            assign mask[i] = (row_width_reg > WIDTH_W'(i));

            assign nb_a.above = pad_above[i+2:i];
            assign nb_a.mid   = pad_pending[i+2:i];
            assign nb_a.below = pad_in[i+2:i];

            assign nb_b.above = pad_up[i+2:i];
            assign nb_b.mid   = pad_in[i+2:i];
            assign nb_b.below = 3'b000;

            carow_lane u_lane_a (
                .nb        (nb_a),
                .active    (mask[i]),
                .cell_next (next_a[i])
            );

            carow_lane u_lane_b (
                .nb        (nb_b),
                .active    (mask[i]),
                .cell_next (next_b[i])
            );
        end
    endgenerate

    assign push.push_a = accept & pending_valid_reg;
    assign push.push_b = accept & s_last_row;

    always_comb begin
        row_above_next     = row_above_reg;
        row_pending_next   = row_pending_reg;
        pending_valid_next = pending_valid_reg;
        if (accept) begin
            if (s_last_row) begin
                row_above_next     = '0;
                row_pending_next   = '0;
                pending_valid_next = 1'b0;
            end else begin
                row_above_next     = row_up;
                row_pending_next   = row_in;
                pending_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg     <= WIDTH_RESET;
            row_above_reg     <= '0;
            row_pending_reg   <= '0;
            pending_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                row_width_reg <= cfg_wr_data;
            end
            row_above_reg     <= row_above_next;
            row_pending_reg   <= row_pending_next;
            pending_valid_reg <= pending_valid_next;
        end
    end

    carow_queue #(
        .W (MAX_WIDTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .row_a    (next_a),
        .row_b    (next_b),
        .space_ok (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_row    (q_row),
        .m_end    (m_frame_end)
    );

    assign m_next_cells = CELLS_W'(q_row);

endmodule

>>> design/carow_checker.sv
// Port-level checker for cellular_automaton_row_step, bound to the top level.
// Depends on carow_pkg and cellular_automaton_row_step_assert.svh.
`include "cellular_automaton_row_step_assert.svh"

module carow_checker
    import carow_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_last_row,
    input logic               m_valid,
    input logic               m_ready,
    input logic [CELLS_W-1:0] m_next_cells,
    input logic               m_frame_end
);

    `CA_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> (!m_valid && s_ready), "not empty after reset")
    `CA_ASSERT(a_last_emits, (s_valid && s_ready && s_last_row) |=> m_valid, "last row gave no word")
    `CA_ASSERT(a_out_hold, (m_valid && !m_ready) |=> m_valid, "result word dropped")
    `CA_ASSERT(a_out_stable, (m_valid && !m_ready) |=> $stable({m_next_cells, m_frame_end}), "result word changed")

endmodule

bind cellular_automaton_row_step carow_checker u_carow_checker (.*);

>>> tb/tb_cellular_automaton_row_step.sv
`timescale 1ns / 1ps
// Testbench for cellular_automaton_row_step: streams grid rows, predicts each
// next-generation row word and checks it in order. Depends on carow_pkg and the RTL.

class generation_board;
    logic [carow_pkg::WIDTH_W-1:0] row_width;
    logic [63:0] above_row;
    logic [63:0] held_row;
    bit          held_ok;
    typedef struct {
        logic [63:0] cells;
        logic        fend;
    } row_word_t;
    row_word_t   due[$];
    int          errors;

    function new();
        row_width = carow_pkg::WIDTH_RESET;
        above_row = '0;
        held_row  = '0;
        held_ok   = 0;
        errors    = 0;
    endfunction

    function logic [63:0] lanes();
        if (row_width >= 64) return '1;
        return (64'd1 << row_width) - 64'd1;
    endfunction

    function logic [63:0] next_generation(logic [63:0] a, logic [63:0] c,
                                          logic [63:0] b, logic [63:0] m);
        logic [63:0] orth;
        logic [63:0] all8;
        orth = a | b | (c << 1) | (c >> 1);
        all8 = orth | (a << 1) | (a >> 1) | (b << 1) | (b >> 1);
        return ((~c & ~orth) | (c & ~all8)) & m;
    endfunction

    function void report(string msg);
        errors++;
        if (errors <= 10) $display("%s", msg);
    endfunction

    function void take_row(logic [63:0] cells, logic last);
        logic [63:0] m;
        logic [63:0] r;
        row_word_t   w;
        m = lanes();
        r = cells & m;
        if (held_ok) begin
            w.cells = next_generation(above_row, held_row, r, m);
            w.fend  = 1'b0;
            due.push_back(w);
        end
        if (last) begin
            w.cells = next_generation(held_ok ? held_row : 64'd0, r, 64'd0, m);
            w.fend  = 1'b1;
            due.push_back(w);
            above_row = '0;
            held_row  = '0;
            held_ok   = 0;
        end else begin
            above_row = held_ok ? held_row : 64'd0;
            held_row  = r;
            held_ok   = 1;
        end
    endfunction

    function void check_row(logic [63:0] cells, logic fend);
        row_word_t w;
        if (due.size() == 0) begin
            report($sformatf("unexpected word: cells %h frame_end %0b", cells, fend));
            return;
        end
        w = due.pop_front();
        if (w.cells !== cells || w.fend !== fend)
            report($sformatf("word mismatch: expected %h/%0b, got %h/%0b",
                             w.cells, w.fend, cells, fend));
    endfunction
endclass

module tb_cellular_automaton_row_step;
    import carow_pkg::*;

    localparam int LATENCY   = 4;
    localparam int LIMIT     = 500000;
    localparam int ROW_COUNT = 1550;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [WIDTH_W-1:0] cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [CELLS_W-1:0] s_row_cells = '0;
    logic               s_last_row = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [CELLS_W-1:0] m_next_cells;
    logic               m_frame_end;

    generation_board board = new();
    int  cycles = 0;
    int  sent = 0;
    bit  calm = 0;

    cellular_automaton_row_step #(.MAX_WIDTH(64)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_row_cells (s_row_cells),
        .s_last_row  (s_last_row),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_next_cells(m_next_cells),
        .m_frame_end (m_frame_end)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.take_row(s_row_cells, s_last_row);
            if (m_valid && m_ready) board.check_row(m_next_cells, m_frame_end);
        end
    end

    // result side: random stall before each word
    initial begin
        int gap;
        forever begin
            gap = calm ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_row(logic [63:0] cells, logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_row_cells <= cells;
        s_last_row  <= last;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.due.size() != 0);
    endtask

    task automatic write_width(logic [WIDTH_W-1:0] value);
        drain();
        repeat (LATENCY) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.row_width = value;
    endtask

    function automatic logic [63:0] random_row();
        logic [63:0] r1;
        logic [63:0] r2;
        logic [63:0] r3;
        r1 = {$urandom, $urandom};
        r2 = {$urandom, $urandom};
        r3 = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return r1;
            1: return r1 & r2 & r3;
            2: return r1 & r2 & r3 & {$urandom, $urandom};
            3: return ($urandom_range(0, 3) == 0) ? 64'd0 : (64'd1 << $urandom_range(0, 63));
            4: return r1 | r2;
            default: return ~(r1 & r2 & r3);
        endcase
    endfunction

    initial begin
        int len;
        int phase_end;
        logic [WIDTH_W-1:0] w;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset width: single-row frames, then short frames
        send_row('1, 1'b1);
        send_row('0, 1'b1);
        send_row('1, 1'b0);
        send_row('0, 1'b0);
        send_row('1, 1'b1);
        send_row(64'h1, 1'b0);
        send_row(64'h0, 1'b0);
        send_row(64'h2AAA_AAAA, 1'b1);

        write_width(7'd64);
        send_row('1, 1'b0);
        send_row('0, 1'b1);
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b0);
        send_row('0, 1'b0);
        send_row('1, 1'b1);
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row('0, 1'b0);
        send_row('0, 1'b1);

        // no active lanes
        write_width(7'd0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);

        // saturates to the full row
        write_width(7'd127);
        send_row('1, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b1);

        write_width(7'd1);
        send_row('1, 1'b0);
        send_row('0, 1'b0);
        send_row('1, 1'b1);

        while (sent < ROW_COUNT) begin
            case ($urandom_range(0, 9))
                0: w = 7'd0;
                1: w = 7'd1;
                2: w = 7'd64;
                3: w = 7'($urandom_range(65, 127));
                default: w = 7'($urandom_range(1, 64));
            endcase
            write_width(w);
            calm = ($urandom_range(0, 3) == 0);
            phase_end = sent + $urandom_range(40, 100);
            while (sent < phase_end) begin
                len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 150) == 0) drain();
                    send_row(random_row(), i == len - 1);
                end
            end
            calm = 0;
        end

        drain();
        repeat (2 * LATENCY) @(posedge aclk);
        if (board.errors == 0 && board.due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/carow_pkg.sv
design/carow_lane.sv
design/carow_queue.sv
design/cellular_automaton_row_step.sv
design/carow_checker.sv
tb/tb_cellular_automaton_row_step.sv
